// ===== design/setq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_pkg: shared types and constants for the sorted expiry timer queue.
// Holds request and status codes, table sizing and the front-to-back command.
// ----------------------------------------------------------------------------
package setq_pkg;

  localparam int Depth    = 16;
  localparam int IdW      = 4;
  localparam int CntW     = 5;
  localparam int TimeW    = 32;
  localparam int CmdDepth = 2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_ABSENT = 3'd2,
    ST_DUP    = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  // One accepted request as the front hands it to the back.
  typedef struct packed {
    logic [1:0]       req;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] exp_t;
    logic [TimeW-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]     status;
    logic           is_expiry;
    logic [IdW-1:0] expired_id;
    logic           last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_REMOVE,
    S_SEARCH,
    S_INSERT,
    S_TICK,
    S_EMIT
  } bstate_t;

endpackage

// ===== design/setq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_front: request intake.
// Registers accepted requests into a small command queue for the engine.
// ----------------------------------------------------------------------------
module setq_front import setq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  cmd_t             cmd_in,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output cmd_t             cmd_out
);

  cmd_t       q_r [CmdDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'(CmdDepth));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_out   = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cmd_in;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(CmdDepth)) else $error("command queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |=> (cnt_r <= 2'd1)) else $error("command queue underflow");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("command queue lost a push");
`endif

endmodule

// ===== design/setq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_back: timer list engine.
// Walks the ordered list one entry per cycle to find and place timers, removes
// and expires timers, and hands results to a two-entry output queue.
// ----------------------------------------------------------------------------
module setq_back import setq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic res_empty,
  input  logic res_pop,
  output res_t res_out
);

  localparam int PosW = $clog2(Depth);

  logic [Depth-1:0] valid_r;
  logic [TimeW-1:0] expiry_r [Depth];
  logic [IdW-1:0]   order_r  [Depth];
  logic [CntW-1:0]  count_r;

  bstate_t          state_r, state_nxt;
  cmd_t             cur_r;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic             tick_any_r;

  // output queue
  res_t       oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       o_push, o_pop;
  res_t       o_data;

  // engine actions
  logic             take_now;
  logic             shift_left, shift_right;
  logic [CntW-1:0]  shift_pos;
  logic             write_id;
  logic             valid_clr, valid_set, exp_wr;
  logic [IdW-1:0]   head_id;
  logic [PosW-1:0]  pos_ix;
  logic [IdW-1:0]   cur_id;

  assign pos_ix   = pos_r[PosW-1:0];
  assign head_id  = order_r[0];
  assign cur_id   = cur_r.id;
  assign o_pop    = res_pop && !res_empty;
  assign res_empty = (ocnt_r == 2'd0);
  assign res_out  = oq_r[orp_r];
  assign cmd_take = take_now;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    take_now    = 1'b0;
    shift_left  = 1'b0;
    shift_right = 1'b0;
    shift_pos   = pos_r;
    write_id    = 1'b0;
    valid_clr   = 1'b0;
    valid_set   = 1'b0;
    exp_wr      = 1'b0;
    o_push      = 1'b0;
    o_data      = '{status: ST_OK, is_expiry: 1'b0, expired_id: '0, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && ocnt_r == 2'd0) begin
          take_now  = 1'b1;
          pos_nxt   = '0;
          unique case (req_t'(cmd.req))
            REQ_TICK:   state_nxt = S_TICK;
            REQ_ADD: begin
              if (valid_r[cmd.id]) begin
                o_push = 1'b1; o_data.status = ST_DUP;
              end else if (count_r >= CntW'(Depth)) begin
                o_push = 1'b1; o_data.status = ST_FULL;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              if (!valid_r[cmd.id]) begin
                o_push = 1'b1; o_data.status = ST_ABSENT;
              end else begin
                state_nxt = S_FIND;
              end
            end
          endcase
        end
      end
      S_FIND: begin
        if (order_r[pos_ix] == cur_id || pos_r + 1'b1 >= count_r) begin
          state_nxt = S_REMOVE;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_REMOVE: begin
        shift_left = 1'b1;
        pos_nxt    = '0;
        if (req_t'(cur_r.req) == REQ_DELETE) begin
          valid_clr = 1'b1;
          o_push    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          exp_wr    = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // first visit for an add writes the slot
        if (req_t'(cur_r.req) == REQ_ADD && pos_r == '0) begin
          valid_set = 1'b1;
          exp_wr    = 1'b1;
        end
        if (pos_r < count_r && expiry_r[order_r[pos_ix]] <= cur_r.exp_t) begin
          pos_nxt = pos_r + 1'b1;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        shift_right = 1'b1;
        write_id    = 1'b1;
        o_push      = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_TICK: begin
        if (count_r != '0 && cur_r.now >= expiry_r[head_id]) begin
          state_nxt = S_EMIT;
        end else begin
          if (!tick_any_r) begin
            o_push = 1'b1;
            o_data.status = ST_NONE;
          end
          state_nxt = (tick_any_r && ocnt_r == 2'd2) ? S_TICK : S_IDLE;
          if (tick_any_r) begin
            // close the run: the last expiry result already carries the last flag
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        // emit head; last flag set when next head will not expire
        if (ocnt_r != 2'd2) begin
          o_push = 1'b1;
          o_data.is_expiry  = 1'b1;
          o_data.expired_id = head_id;
          o_data.last = !(count_r > CntW'(1) && cur_r.now >= expiry_r[order_r[1]]);
          shift_left = 1'b1;
          shift_pos  = '0;
          valid_clr  = 1'b1;
          state_nxt  = S_TICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      count_r    <= '0;
      pos_r      <= '0;
      tick_any_r <= 1'b0;
      owp_r      <= 1'b0;
      orp_r      <= 1'b0;
      ocnt_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (take_now) tick_any_r <= 1'b0;
      else if (state_r == S_EMIT && o_push) tick_any_r <= 1'b1;
      if (valid_clr) valid_r[(state_r == S_EMIT) ? head_id : cur_id] <= 1'b0;
      if (valid_set) valid_r[cur_id] <= 1'b1;
      count_r <= count_r - CntW'(shift_left) + CntW'(shift_right);
      ocnt_r  <= ocnt_r + 2'(o_push) - 2'(o_pop);
      if (o_push) owp_r <= ~owp_r;
      if (o_pop)  orp_r <= ~orp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_now) cur_r <= cmd;
    if (exp_wr) expiry_r[cur_id] <= cur_r.exp_t;
    if (o_push) oq_r[owp_r] <= o_data;
    for (int i = 0; i < Depth; i++) begin
      if (shift_left && CntW'(i) >= shift_pos && i + 1 < Depth) begin
        order_r[i] <= order_r[i + 1];
      end
      if (shift_right && CntW'(i) > pos_r) begin
        order_r[i] <= order_r[i - 1];
      end
      if (write_id && CntW'(i) == pos_r) begin
        order_r[i] <= cur_id;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth)) else $error("entry count out of range");
  a_oq_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2) else $error("result queue overflow");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take_now |-> (state_r == S_IDLE && cmd_valid))
    else $error("command taken while busy");
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    shift_right |-> (count_r < CntW'(Depth))) else $error("insert into full list");
`endif

endmodule

// ===== design/sorted_expiry_timer_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue_top: sorted timer list with queue-style ports.
// Keeps up to 16 timers, one per id, ordered by ascending expiry.
// ----------------------------------------------------------------------------
// Usage:
// The request channel is a queue write side: a beat moves when in_push is
// high and in_full is low. Each beat carries a request kind, a timer id,
// an expiry time and the current time.
// The result channel is a queue read side: while out_empty is low the oldest
// result sits on the out_ ports, and it moves when out_pop is high.
// Add, adjust and delete each give one result. A tick gives one result per
// expired timer, in expiry order, or one "nothing expired" result.
// The front registers requests in a two-entry command queue, so requests can
// be accepted while the engine works. The engine walks the ordered list one
// entry per cycle to find or place a timer: an add searches for its place and
// inserts, an adjust finds and removes the entry then searches and inserts,
// a delete finds and removes it, and a tick expires timers from the head.
// Results wait in a two-entry queue; when the receiver stalls the engine
// pauses a tick walk and holds new requests until the queue drains.
// Reset (rst_n low, synchronous) empties the list and all queues.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue_top import setq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_req_type,
  input  logic [IdW-1:0]      in_timer_id,
  input  logic [TimeW-1:0]    in_expire_time,
  input  logic [TimeW-1:0]    in_now_time,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_status,
  output logic                out_is_expiry,
  output logic [IdW-1:0]      out_expired_id,
  output logic                out_last_result
);

  cmd_t cmd_in, cmd_q;
  logic cmd_valid, cmd_take;
  res_t res;

  assign cmd_in = '{req: in_req_type, id: in_timer_id,
                    exp_t: in_expire_time, now: in_now_time};

  setq_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full),
    .cmd_in(cmd_in), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_out(cmd_q)
  );

  setq_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd_q),
    .cmd_take(cmd_take), .res_empty(out_empty), .res_pop(out_pop),
    .res_out(res)
  );

  assign out_status      = res.status;
  assign out_is_expiry   = res.is_expiry;
  assign out_expired_id  = res.expired_id;
  assign out_last_result = res.last;

`ifndef NO_ASSERTIONS
  a_exp_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_expiry) |-> (out_expired_id == '0))
    else $error("nonzero id on non-expiry result");
  a_nonexp_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_expiry) |-> out_last_result)
    else $error("non-expiry result not last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)))
    else $error("result changed while stalled");
`endif

endmodule
